FILE: sv/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and codes shared by the delta list timer queue modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dltq_pkg;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [2:0] ST_STARTED   = 3'd0;
   localparam logic [2:0] ST_CANCELLED = 3'd1;
   localparam logic [2:0] ST_EXPIRED   = 3'd2;
   localparam logic [2:0] ST_NO_SLOT   = 3'd3;
   localparam logic [2:0] ST_ZERO_DUR  = 3'd4;
   localparam logic [2:0] ST_NOT_ACT   = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] duration;
      logic        cyclic;
      logic [3:0]  timer_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] reported_id;
      logic       last;
   } rsp_type;

   // Operation applied to the whole chain in one step.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,   // insert slot with duration
      OP_REMOVE,   // unlink slot, add delta to successor
      OP_POP,      // take head (delta zero) out of the list
      OP_DEC       // decrement head delta, saturating
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TICK_CHECK,
      S_TICK_POP,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

FILE: sv/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell
// One position of the sorted active list: slot id and ticks left until expiry.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_cell #(
   parameter int IdW = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dltq_pkg::op_type      op,
   input  wire logic [IdW-1:0]        op_id,
   input  wire logic [15:0]           op_dur,
   input  wire logic                  dec_en,       // head time is nonzero
   // from the left neighbor
   input  wire logic                  left_valid,
   input  wire logic [IdW-1:0]        left_id,
   input  wire logic [15:0]           left_cum,
   input  wire logic                  ins_before,   // insert happened left
   input  wire logic                  rem_before,   // removal happened left
   // from the right neighbor
   input  wire logic                  right_valid,
   input  wire logic [IdW-1:0]        right_id,
   input  wire logic [15:0]           right_cum,
   // to neighbors
   output logic                       valid_ff,
   output logic [IdW-1:0]             id_ff,
   output logic [15:0]                cum_ff,
   output logic                       ins_out,
   output logic                       rem_out
);
   logic             valid_in;
   logic [IdW-1:0]   id_in;
   logic [15:0]      cum_in;
   logic             match;
   logic             ins_here;

   // Hold the absolute time to expiry; the delta is the step from the left.
   always_comb begin
      match    = valid_ff && (id_ff == op_id);
      ins_here = !ins_before && (!valid_ff || (cum_ff > op_dur));
      ins_out  = ins_before || ins_here;
      rem_out  = rem_before || match;
      valid_in = valid_ff;
      id_in    = id_ff;
      cum_in   = cum_ff;
      case (op)
         dltq_pkg::OP_INSERT: begin
            if (ins_before) begin
               // shift right
               valid_in = left_valid;
               id_in    = left_id;
               cum_in   = left_cum;
            end else if (ins_here) begin
               valid_in = 1'b1;
               id_in    = op_id;
               cum_in   = op_dur;
            end
         end
         dltq_pkg::OP_REMOVE, dltq_pkg::OP_POP: begin
            if (rem_out) begin
               // shift left
               valid_in = right_valid;
               id_in    = right_id;
               cum_in   = right_cum;
            end
         end
         dltq_pkg::OP_DEC: begin
            if (dec_en && valid_ff)
               cum_in = cum_ff - 16'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff  <= id_in;
      cum_ff <= cum_in;
   end
endmodule
`default_nettype wire

FILE: sv/dltq_chain.sv
// ----------------------------------------------------------------------------
// dltq_chain
// Row of list cells, position 0 is the list head.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_chain #(
   parameter int SlotCount = 16,
   parameter int IdW       = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dltq_pkg::op_type     op,
   input  wire logic [IdW-1:0]       op_id,
   input  wire logic [15:0]          op_dur,
   output logic                      head_valid,
   output logic [IdW-1:0]            head_id,
   output logic [15:0]               head_delta
);
   logic                 v   [SlotCount];
   logic [IdW-1:0]       ids [SlotCount];
   logic [15:0]          cm  [SlotCount];
   logic                 ins [SlotCount+1];
   logic                 rem [SlotCount+1];
   logic                 lv  [SlotCount];
   logic [IdW-1:0]       lid [SlotCount];
   logic [15:0]          lcm [SlotCount];
   logic                 rv  [SlotCount];
   logic [IdW-1:0]       rid [SlotCount];
   logic [15:0]          rcm [SlotCount];
   logic                 dec_en;

   assign ins[0] = 1'b0;
   assign rem[0] = 1'b0;
   // Every time moves down by one only while the head is not yet due.
   assign dec_en = v[0] && (cm[0] != 16'd0);

   for (genvar i = 0; i < SlotCount; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lv[i]  = 1'b0;
         assign lid[i] = '0;
         assign lcm[i] = '0;
      end else begin : g_left
         assign lv[i]  = v[i-1];
         assign lid[i] = ids[i-1];
         assign lcm[i] = cm[i-1];
      end
      if (i == SlotCount-1) begin : g_last
         assign rv[i]  = 1'b0;
         assign rid[i] = '0;
         assign rcm[i] = '0;
      end else begin : g_right
         assign rv[i]  = v[i+1];
         assign rid[i] = ids[i+1];
         assign rcm[i] = cm[i+1];
      end
      dltq_cell #(.IdW(IdW)) u_cell (
         .clock, .reset, .op, .op_id, .op_dur, .dec_en,
         .left_valid(lv[i]), .left_id(lid[i]), .left_cum(lcm[i]),
         .ins_before(ins[i]), .rem_before(rem[i]),
         .right_valid(rv[i]), .right_id(rid[i]), .right_cum(rcm[i]),
         .valid_ff(v[i]), .id_ff(ids[i]), .cum_ff(cm[i]),
         .ins_out(ins[i+1]), .rem_out(rem[i+1])
      );
   end

   assign head_valid = v[0];
   assign head_id    = ids[0];
   assign head_delta = cm[0];
endmodule
`default_nettype wire

FILE: sv/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Pool of software timers held as a delta-sorted list in a row of cells.
// ----------------------------------------------------------------------------
//   channel | dir | ports                        | payload
//   request | in  | req_valid, req_stall, req_*  | dltq_pkg::req_type
//   result  | out | rsp_valid, rsp_stall, rsp_*  | dltq_pkg::rsp_type
//
// Start and cancel step through accept, decode and result. A tick steps
// through accept, decode and a check, and gives no result when nothing is
// due; each of up to 16 expiries costs a check, a pop and a result.
// An unknown code is accepted and decoded and gives no result.
// Reset is synchronous: the list empties and the free stack pops 0,1,2...
// A stalled result holds; no new request is taken until results drain.
// ----------------------------------------------------------------------------
`default_nettype none
module delta_list_timer_queue_core #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire dltq_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output dltq_pkg::rsp_type       rsp_data
);
   localparam int IdW = $clog2(SLOT_COUNT);

   dltq_pkg::state_type state_ff, state_in;
   dltq_pkg::req_type   req_ff, req_in;
   dltq_pkg::rsp_type   rsp_ff, rsp_in;
   dltq_pkg::op_type    op;
   logic [IdW-1:0]      op_id;
   logic [15:0]         op_dur;
   logic [4:0]          nrep_ff, nrep_in;
   logic                after_ff, after_in;  // tick: return to check after out
   logic [IdW-1:0]      pid_ff, pid_in;      // slot taken off the head

   // Free stack, reload info and active flag per slot.
   logic [IdW:0]        link_ff  [SLOT_COUNT];
   logic [IdW:0]        link_in  [SLOT_COUNT];
   logic [15:0]         rel_ff   [SLOT_COUNT];
   logic [15:0]         rel_in   [SLOT_COUNT];
   logic                cyc_ff   [SLOT_COUNT];
   logic                cyc_in   [SLOT_COUNT];
   logic                act_ff   [SLOT_COUNT];
   logic                act_in   [SLOT_COUNT];
   logic [IdW:0]        fhead_ff, fhead_in;

   logic                head_valid;
   logic [IdW-1:0]      head_id;
   logic [15:0]         head_delta;
   logic [IdW-1:0]      cid, fid;

   dltq_chain #(.SlotCount(SLOT_COUNT), .IdW(IdW)) u_chain (
      .clock, .reset, .op, .op_id, .op_dur,
      .head_valid, .head_id, .head_delta
   );

   assign req_stall = (state_ff != dltq_pkg::S_IDLE);
   assign rsp_valid = (state_ff == dltq_pkg::S_OUT);
   assign rsp_data  = rsp_ff;
   assign cid       = IdW'(req_ff.timer_id);
   assign fid       = fhead_ff[IdW-1:0];

   // Next state and bookkeeping.
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      nrep_in  = nrep_ff;
      after_in = after_ff;
      pid_in   = pid_ff;
      fhead_in = fhead_ff;
      link_in  = link_ff;
      rel_in   = rel_ff;
      cyc_in   = cyc_ff;
      act_in   = act_ff;
      op       = dltq_pkg::OP_NONE;
      op_id    = '0;
      op_dur   = '0;
      unique case (state_ff)
         dltq_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = dltq_pkg::S_DECODE;
            end
         end
         dltq_pkg::S_DECODE: begin
            after_in = 1'b0;
            nrep_in  = '0;
            state_in = dltq_pkg::S_OUT;
            case (req_ff.command)
               dltq_pkg::CMD_START: begin
                  if (fhead_ff >= (IdW+1)'(SLOT_COUNT)) begin
                     rsp_in = '{dltq_pkg::ST_NO_SLOT, 4'd0, 1'b1};
                  end else if (req_ff.duration == 16'd0) begin
                     rsp_in = '{dltq_pkg::ST_ZERO_DUR, 4'd0, 1'b1};
                  end else begin
                     op       = dltq_pkg::OP_INSERT;
                     op_id    = fid;
                     op_dur   = req_ff.duration;
                     fhead_in = link_ff[fid];
                     rel_in[fid] = req_ff.duration;
                     cyc_in[fid] = req_ff.cyclic;
                     act_in[fid] = 1'b1;
                     rsp_in = '{dltq_pkg::ST_STARTED, 4'(fid), 1'b1};
                  end
               end
               dltq_pkg::CMD_CANCEL: begin
                  if ((32'(req_ff.timer_id) < SLOT_COUNT) && act_ff[cid]) begin
                     op       = dltq_pkg::OP_REMOVE;
                     op_id    = cid;
                     act_in[cid]  = 1'b0;
                     rel_in[cid]  = '0;
                     cyc_in[cid]  = 1'b0;
                     link_in[cid] = fhead_ff;
                     fhead_in     = {1'b0, cid};
                     rsp_in = '{dltq_pkg::ST_CANCELLED, 4'(cid), 1'b1};
                  end else begin
                     rsp_in = '{dltq_pkg::ST_NOT_ACT, 4'd0, 1'b1};
                  end
               end
               dltq_pkg::CMD_TICK: state_in = dltq_pkg::S_TICK_CHECK;
               default: state_in = dltq_pkg::S_IDLE;
            endcase
         end
         dltq_pkg::S_TICK_CHECK: begin
            if (head_valid && head_delta == 16'd0 && nrep_ff < 5'd16) begin
               op       = dltq_pkg::OP_POP;
               op_id    = head_id;
               pid_in   = head_id;
               rsp_in   = '{dltq_pkg::ST_EXPIRED, 4'(head_id), 1'b0};
               state_in = dltq_pkg::S_TICK_POP;
            end else begin
               op       = dltq_pkg::OP_DEC;
               state_in = dltq_pkg::S_IDLE;
            end
         end
         dltq_pkg::S_TICK_POP: begin
            // Reinsert cyclic slot or return it to the free stack.
            if (cyc_ff[pid_ff] && rel_ff[pid_ff] != 16'd0) begin
               op     = dltq_pkg::OP_INSERT;
               op_id  = pid_ff;
               op_dur = rel_ff[pid_ff];
            end else begin
               act_in[pid_ff]  = 1'b0;
               rel_in[pid_ff]  = '0;
               cyc_in[pid_ff]  = 1'b0;
               link_in[pid_ff] = fhead_ff;
               fhead_in = {1'b0, pid_ff};
            end
            nrep_in  = nrep_ff + 5'd1;
            after_in = 1'b1;
            state_in = dltq_pkg::S_TICK_CHECK;
            // Peek: more expiries follow only if the new head is due.
            if (!(head_valid && head_delta == 16'd0 && nrep_ff < 5'd15))
               rsp_in.last = 1'b1;
            state_in = dltq_pkg::S_OUT;
         end
         dltq_pkg::S_OUT: begin
            if (!rsp_stall)
               state_in = after_ff ? dltq_pkg::S_TICK_CHECK : dltq_pkg::S_IDLE;
            if (!rsp_stall && after_ff && rsp_ff.last) begin
               op       = dltq_pkg::OP_DEC;
               state_in = dltq_pkg::S_IDLE;
            end
         end
         default: state_in = dltq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dltq_pkg::S_IDLE;
         fhead_ff <= '0;
         after_ff <= 1'b0;
         nrep_ff  <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            link_ff[i] <= (IdW+1)'(i + 1);
            act_ff[i]  <= 1'b0;
            cyc_ff[i]  <= 1'b0;
            rel_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         fhead_ff <= fhead_in;
         after_ff <= after_in;
         nrep_ff  <= nrep_in;
         link_ff  <= link_in;
         act_ff   <= act_in;
         cyc_ff   <= cyc_in;
         rel_ff   <= rel_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      pid_ff <= pid_in;
   end
endmodule
`default_nettype wire

FILE: bench/tb_delta_list_timer_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_list_timer_queue_core
// Drives start, cancel and tick requests into the timer queue with random
// gaps and result back-pressure. A scoreboard keeps its own delta-sorted
// timer list, predicts the results of each accepted request and checks every
// result field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_delta_list_timer_queue_core;

   localparam int NSLOT   = 16;
   localparam int NIL     = NSLOT;
   localparam int MAX_EXP = 16;

   // Scoreboard: shadow copy of the timer pool and the pending results.
   class timer_scoreboard;
      bit [15:0] delta[NSLOT];
      bit [15:0] reload[NSLOT];
      bit        cyc[NSLOT];
      bit        active[NSLOT];
      int        link[NSLOT];
      int        act_head;
      int        free_head;
      dltq_pkg::rsp_type pending[$];
      int        errors;
      int        n_results;
      int        n_expired;

      function void clear();
         for (int i = 0; i < NSLOT; i++) begin
            delta[i] = 0;
            reload[i] = 0;
            cyc[i] = 0;
            active[i] = 0;
            link[i] = i + 1;
         end
         act_head = NIL;
         free_head = 0;
         pending.delete();
         errors = 0;
         n_results = 0;
         n_expired = 0;
      endfunction

      function int free_slots();
         int n;
         int c;
         n = 0;
         c = free_head;
         while (c < NSLOT && n <= NSLOT) begin
            n++;
            c = link[c];
         end
         return n;
      endfunction

      function void release_slot(int s);
         delta[s] = 0;
         reload[s] = 0;
         cyc[s] = 0;
         active[s] = 0;
         link[s] = free_head;
         free_head = s;
      endfunction

      // Walk past every entry whose running sum stays at or below dur.
      function void link_in(int s, bit [15:0] dur);
         int        prev;
         int        cur;
         int        steps;
         bit [16:0] sum;
         prev = NIL;
         cur = act_head;
         sum = 0;
         steps = 0;
         while (cur < NSLOT && steps < NSLOT) begin
            if (sum + delta[cur] > dur) break;
            sum += delta[cur];
            prev = cur;
            cur = link[cur];
            steps++;
         end
         delta[s] = dur - sum[15:0];
         link[s] = cur;
         if (cur < NSLOT) delta[cur] = delta[cur] - delta[s];
         if (prev < NSLOT) link[prev] = s;
         else act_head = s;
         active[s] = 1;
      endfunction

      function void add(dltq_pkg::rsp_type r);
         pending.push_back(r);
      endfunction

      function dltq_pkg::rsp_type mk(logic [2:0] st, int id);
         dltq_pkg::rsp_type r;
         r.status = st;
         r.reported_id = id[3:0];
         r.last = 1'b0;
         return r;
      endfunction

      // Note an accepted request and queue the results it causes.
      function void note_request(dltq_pkg::req_type q);
         dltq_pkg::rsp_type outs[$];
         int      s;
         int      prev;
         int      cur;
         int      steps;
         bit      found;
         case (q.command)
            dltq_pkg::CMD_START: begin
               s = free_head;
               if (s >= NSLOT) outs.push_back(mk(dltq_pkg::ST_NO_SLOT, 0));
               else if (q.duration == 0) outs.push_back(mk(dltq_pkg::ST_ZERO_DUR, 0));
               else begin
                  free_head = link[s];
                  reload[s] = q.duration;
                  cyc[s] = q.cyclic;
                  link_in(s, q.duration);
                  outs.push_back(mk(dltq_pkg::ST_STARTED, s));
               end
            end
            dltq_pkg::CMD_CANCEL: begin
               prev = NIL;
               cur = act_head;
               steps = 0;
               found = 0;
               if (active[q.timer_id]) begin
                  while (cur < NSLOT && steps < NSLOT) begin
                     if (cur == q.timer_id) begin
                        found = 1;
                        break;
                     end
                     prev = cur;
                     cur = link[cur];
                     steps++;
                  end
               end
               if (!found) outs.push_back(mk(dltq_pkg::ST_NOT_ACT, 0));
               else begin
                  s = link[cur];
                  if (prev < NSLOT) link[prev] = s;
                  else act_head = s;
                  if (s < NSLOT) delta[s] = delta[s] + delta[cur];
                  release_slot(cur);
                  outs.push_back(mk(dltq_pkg::ST_CANCELLED, cur));
               end
            end
            dltq_pkg::CMD_TICK: begin
               while (act_head < NSLOT && delta[act_head] == 0
                      && outs.size() < MAX_EXP) begin
                  s = act_head;
                  act_head = link[s];
                  outs.push_back(mk(dltq_pkg::ST_EXPIRED, s));
                  n_expired++;
                  if (cyc[s] && reload[s] != 0) link_in(s, reload[s]);
                  else release_slot(s);
               end
               if (act_head < NSLOT && delta[act_head] != 0)
                  delta[act_head]--;
            end
            default: ;
         endcase
         if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
         foreach (outs[i]) add(outs[i]);
      endfunction

      function void check_result(dltq_pkg::rsp_type got);
         dltq_pkg::rsp_type want;
         n_results++;
         if (pending.size() == 0) begin
            $error("unexpected result status=%0d id=%0d", got.status, got.reported_id);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.reported_id !== want.reported_id) begin
            $error("reported_id: expected %0d, got %0d", want.reported_id,
                   got.reported_id);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   dltq_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   dltq_pkg::rsp_type rsp_data;

   timer_scoreboard sb;
   bit  quiet;        // no idling in the final stretch
   bit  hold_rsp;     // long receiver hold-off in progress
   bit  hold_req;     // request side asks for a hold-off
   int  n_sent;
   int  n_stall_seen;

   delta_list_timer_queue_core #(.SLOT_COUNT(NSLOT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Hard limit: slowest run is far below this.
   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // Check every result accepted at a rising edge; count input stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (!reset && req_valid && req_stall) n_stall_seen++;
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_rsp = 1'b1;
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall = 1'b0;
            hold_rsp = 1'b0;
            wait (!hold_req);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall = 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall = 1'b0;
         end
         @(negedge clock);
      end
   end

   // Offer one request and hold it until accepted; note it at the edge.
   task automatic send_request(logic [1:0] cmd, logic [15:0] dur, logic cy,
                               logic [3:0] id);
      dltq_pkg::req_type q;
      int      gap;
      q.command = cmd;
      q.duration = dur;
      q.cyclic = cy;
      q.timer_id = id;
      if (!quiet && !hold_rsp && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = q;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
      n_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_tick();
      send_request(dltq_pkg::CMD_TICK, 16'($urandom), 1'($urandom), 4'($urandom));
   endtask

   // Start a timer with the given duration; cyclic flag and id are random.
   task automatic send_start(logic [15:0] dur);
      send_request(dltq_pkg::CMD_START, dur, 1'($urandom), 4'($urandom));
   endtask

   // Mostly cancel a live slot, sometimes a free or random one.
   task automatic send_cancel();
      int id;
      id = $urandom_range(0, NSLOT - 1);
      if ($urandom_range(0, 3) != 0)
         for (int i = 0; i < NSLOT; i++)
            if (sb.active[(id + i) % NSLOT]) begin
               id = (id + i) % NSLOT;
               break;
            end
      send_request(dltq_pkg::CMD_CANCEL, 16'($urandom), 1'($urandom), id[3:0]);
   endtask

   initial begin
      int      pick;
      int      waitc;
      sb = new();
      sb.clear();
      quiet = 0;
      hold_req = 0;
      hold_rsp = 0;
      n_sent = 0;
      n_stall_seen = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: errors, extremes, equal durations, cancel cases.
      send_request(dltq_pkg::CMD_CANCEL, 16'd0, 1'b0, 4'd0);   // nothing active
      send_request(dltq_pkg::CMD_START, 16'd0, 1'b1, 4'hF);    // zero duration
      send_request(dltq_pkg::CMD_TICK, 16'hFFFF, 1'b1, 4'hF);  // empty list tick
      send_request(2'd3, 16'hFFFF, 1'b1, 4'hF);                // ignored code
      send_request(dltq_pkg::CMD_START, 16'hFFFF, 1'b0, 4'd0); // longest
      send_request(dltq_pkg::CMD_START, 16'd1, 1'b1, 4'd0);    // cyclic of 1
      send_request(dltq_pkg::CMD_START, 16'd2, 1'b0, 4'd0);
      send_request(dltq_pkg::CMD_START, 16'd2, 1'b0, 4'd0);    // equal sum
      send_request(dltq_pkg::CMD_CANCEL, 16'd0, 1'b0, 4'd2);   // middle of list
      send_tick();
      send_tick();
      send_tick();
      send_request(dltq_pkg::CMD_CANCEL, 16'd0, 1'b0, 4'd0);   // long timer
      send_request(dltq_pkg::CMD_CANCEL, 16'd0, 1'b0, 4'd1);   // cyclic one
      // Fill all slots with one-shot 1-tick timers, then overflow.
      for (int i = 0; i < NSLOT; i++)
         send_request(dltq_pkg::CMD_START, 16'd1, 1'b0, 4'd0);
      send_request(dltq_pkg::CMD_START, 16'd5, 1'b0, 4'd0);    // no free slot
      send_tick();
      send_tick();                                             // all sixteen expire

      // Random: mostly starts and ticks with short durations.
      for (int k = 0; k < 300; k++) begin
         if (k == 100) hold_req = 1;   // receiver holds off, input backs up
         if (k == 130) hold_req = 0;
         if (k == 260) quiet = 1;
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            case ($urandom_range(0, 9))
               0:       send_start(16'd0);
               1:       send_start(16'($urandom));
               2:       send_start(16'hFFFF);
               default: send_start(16'($urandom_range(1, 6)));
            endcase
         end else if (pick < 50) send_cancel();
         else if (pick < 52)
            send_request(2'd3, 16'($urandom), 1'($urandom), 4'($urandom));
         else send_tick();
      end
      // Drain all timers that are close to expiring.
      for (int k = 0; k < 20; k++) send_tick();

      waitc = 0;
      while (sb.pending.size() != 0 && waitc < 100000) begin
         @(negedge clock);
         waitc++;
      end
      repeat (100) @(negedge clock);

      $display("covered %0d requests, %0d results (%0d expiries), %0d stalled offers",
               n_sent, sb.n_results, sb.n_expired, n_stall_seen);
      $display("free slots at end: %0d", sb.free_slots());
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
sv/dltq_pkg.sv
sv/dltq_cell.sv
sv/dltq_chain.sv
sv/delta_list_timer_queue_core.sv
bench/tb_delta_list_timer_queue_core.sv
